// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FIELD_WIDTH    = 32;
  localparam int unsigned OCC_WIDTH      = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                          operation;
    logic signed [FIELD_WIDTH-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] out_value;
    status_e                       status;
    logic [OCC_WIDTH-1:0]          occupancy;
  } spq_out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_ctl_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Sorted min priority queue built as a chain of compare/shift cells.
// The result is registered in the cycle after the input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; every cell compares against the
// broadcast value and shifts to its neighbor in the same cycle.
// Reset clears the entry count and the output valid; cell contents stay
// undefined until written and are never read past the count.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_out_t out_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q;
  spq_out_t              out_data_q, out_data_d;
  logic                  accept, full, empty;
  spq_ctl_t              ctl;
  logic [DATA_WIDTH-1:0] new_val;
  logic [DATA_WIDTH+FIELD_WIDTH-1:0] in_ext;
  logic [DATA_WIDTH+FIELD_WIDTH-1:0] out_ext;
  logic [CW+OCC_WIDTH-1:0]           occ_ext;
  logic [DATA_WIDTH-1:0] cell_val [DEPTH];
  logic                  cell_le  [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = count_q == CW'(DEPTH);
  assign empty      = count_q == '0;

  assign ctl.push = accept && (in_data_i.operation == OP_ENQ) && !full;
  assign ctl.pop  = accept && (in_data_i.operation == OP_DEQ) && !empty;

  assign in_ext  = {{DATA_WIDTH{1'b0}}, in_data_i.value};
  assign new_val = in_ext[DATA_WIDTH-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val, right_val;
    logic                  left_le;
    if (i == 0) begin : g_first
      assign left_val = new_val;
      assign left_le  = 1'b1;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
      assign left_le  = cell_le[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end
    spq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_WIDTH (CW),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .count_i    (count_q),
      .value_i    (new_val),
      .left_val_i (left_val),
      .left_le_i  (left_le),
      .right_val_i(right_val),
      .val_o      (cell_val[i]),
      .le_o       (cell_le[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.push) begin
      count_d = count_q + CW'(1);
    end else if (ctl.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  assign out_ext = {{FIELD_WIDTH{1'b0}}, cell_val[0]};
  assign occ_ext = {{OCC_WIDTH{1'b0}}, count_d};

  always_comb begin
    out_data_d.out_value = '0;
    out_data_d.status    = STATUS_OK;
    out_data_d.occupancy = occ_ext[OCC_WIDTH-1:0];
    if (in_data_i.operation == OP_DEQ) begin
      if (empty) begin
        out_data_d.status = STATUS_EMPTY;
      end else begin
        out_data_d.out_value = out_ext[FIELD_WIDTH-1:0];
      end
    end else if (full) begin
      out_data_d.status = STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.operation == OP_ENQ) && full) |=>
      (out_data_o.status == STATUS_FULL) && $stable(count_q))
    else $error("enqueue into full store not dropped");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pop |=> count_q == $past(count_q) - CW'(1))
    else $error("dequeue did not decrement count");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(2)) |-> ($signed(cell_val[0]) <= $signed(cell_val[1])))
    else $error("head entry out of order");
`endif

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell import spq_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned CNT_WIDTH  = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  spq_ctl_t              ctl_i,
  input  logic [CNT_WIDTH-1:0]  count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_val_i,
  input  logic                  left_le_i,
  input  logic [DATA_WIDTH-1:0] right_val_i,
  output logic [DATA_WIDTH-1:0] val_o,
  output logic                  le_o
);

  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  occupied;

  assign occupied = CNT_WIDTH'(IDX) < count_i;
  assign le_o     = occupied && ($signed(val_q) <= $signed(value_i));
  assign val_o    = val_q;

  // insert point is the first cell that is empty or holds a value > the new value
  always_comb begin
    val_d = val_q;
    if (ctl_i.push) begin
      if (!le_o) begin
        val_d = left_le_i ? value_i : left_val_i;
      end
    end else if (ctl_i.pop) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
